// ===== rtl/text_console_cursor_control_assert.svh =====
// Assertion macros shared by the console checker.
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("console checker: same-cycle rule violated");

// Next-cycle implication, disabled while reset is asserted.
`define TCCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("console checker: next-cycle rule violated");

`endif

// ===== rtl/tccc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tccc_pkg;

	// Screen geometry
	localparam int COLUMNS = 60;
	localparam int ROWS    = 20;

	// Field widths
	localparam int COL_W  = 6;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;

	// Display command codes
	typedef enum logic [1:0] {
		CMD_POSITION = 2'd0,
		CMD_WRITE    = 2'd1,
		CMD_CLEAR    = 2'd2,
		CMD_SCROLL   = 2'd3
	} cmd_code_t;

	// Control characters
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		KIND_PRINT,
		KIND_FF,
		KIND_BS,
		KIND_CR,
		KIND_LF
	} char_kind_t;

	typedef enum logic [1:0] {COL_HOLD, COL_ZERO, COL_DEC, COL_INC} col_op_t;
	typedef enum logic [1:0] {ROW_HOLD, ROW_ZERO, ROW_INC} row_op_t;
	typedef enum logic [1:0] {LINE_HOLD, LINE_CLR, LINE_INC} line_op_t;
	typedef enum logic {CSEL_ZERO, CSEL_CUR} col_sel_t;
	typedef enum logic [1:0] {RSEL_ZERO, RSEL_CUR, RSEL_NEXT, RSEL_LINE} row_sel_t;
	typedef enum logic [1:0] {GSEL_ZERO, GSEL_CHAR, GSEL_SPACE} glyph_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic       load_char;
		col_op_t    col_op;
		row_op_t    row_op;
		line_op_t   line_op;
		logic       emit;
		cmd_code_t  cmd;
		col_sel_t   col_sel;
		row_sel_t   row_sel;
		glyph_sel_t glyph_sel;
		logic       last;
	} tccc_ctl_t;

	// Datapath to controller
	typedef struct packed {
		char_kind_t kind;
		logic       col_zero;
		logic       col_end;
		logic       row_bottom;
		logic       line_end;
		logic       out_free;
	} tccc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tccc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tccc_dp import tccc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire tccc_ctl_t         ctl,
	output tccc_stat_t             stat,
	input  wire logic              cmd_stall,
	output logic                   cmd_valid,
	output logic [1:0]             command,
	output logic [COL_W-1:0]       column,
	output logic [ROW_W-1:0]       row,
	output logic [CHAR_W-1:0]      glyph,
	output logic                   last
);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  line_q;
	logic [CHAR_W-1:0] char_q;
	logic              cmd_valid_q;
	logic [1:0]        command_q;
	logic [COL_W-1:0]  column_q;
	logic [ROW_W-1:0]  row_out_q;
	logic [CHAR_W-1:0] glyph_q;
	logic              last_q;

	logic [COL_W-1:0]  col_mux;
	logic [ROW_W-1:0]  row_mux;
	logic [CHAR_W-1:0] glyph_mux;
	char_kind_t        kind;

	// Classify the incoming byte
	always_comb begin
		case (char_code)
			CH_FF:   kind = KIND_FF;
			CH_BS:   kind = KIND_BS;
			CH_CR:   kind = KIND_CR;
			CH_LF:   kind = KIND_LF;
			default: kind = KIND_PRINT;
		endcase
	end

	// Status back to the controller
	assign stat.kind       = kind;
	assign stat.col_zero   = (col_q == '0);
	assign stat.col_end    = (col_q >= COL_W'(COLUMNS - 1));
	assign stat.row_bottom = (row_q >= ROW_W'(ROWS - 1));
	assign stat.line_end   = (line_q >= ROW_W'(ROWS - 1));
	assign stat.out_free   = !cmd_valid_q || !cmd_stall;

	// Cursor and clear-line counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			line_q <= '0;
		end else begin
			case (ctl.col_op)
				COL_ZERO: col_q <= '0;
				COL_DEC:  col_q <= col_q - COL_W'(1);
				COL_INC:  col_q <= col_q + COL_W'(1);
				default:  col_q <= col_q;
			endcase
			case (ctl.row_op)
				ROW_ZERO: row_q <= '0;
				ROW_INC:  row_q <= row_q + ROW_W'(1);
				default:  row_q <= row_q;
			endcase
			case (ctl.line_op)
				LINE_CLR: line_q <= '0;
				LINE_INC: line_q <= line_q + ROW_W'(1);
				default:  line_q <= line_q;
			endcase
		end
	end

	// Held character for the write command
	always_ff @(posedge clk) begin
		if (ctl.load_char) begin
			char_q <= char_code;
		end
	end

	// Field selection for the next output word
	always_comb begin
		case (ctl.col_sel)
			CSEL_CUR: col_mux = col_q;
			default:  col_mux = '0;
		endcase
		case (ctl.row_sel)
			RSEL_CUR:  row_mux = row_q;
			RSEL_NEXT: row_mux = row_q + ROW_W'(1);
			RSEL_LINE: row_mux = line_q;
			default:   row_mux = '0;
		endcase
		case (ctl.glyph_sel)
			GSEL_CHAR:  glyph_mux = char_q;
			GSEL_SPACE: glyph_mux = CH_SPACE;
			default:    glyph_mux = '0;
		endcase
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			cmd_valid_q <= 1'b1;
		end else if (!cmd_stall) begin
			cmd_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			command_q <= ctl.cmd;
			column_q  <= col_mux;
			row_out_q <= row_mux;
			glyph_q   <= glyph_mux;
			last_q    <= ctl.last;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign command   = command_q;
	assign column    = column_q;
	assign row       = row_out_q;
	assign glyph     = glyph_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== rtl/tccc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tccc_ctrl import tccc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_valid,
	output logic            char_stall,
	input  wire tccc_stat_t stat,
	output tccc_ctl_t       ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FF_POS,
		S_FF_CLR,
		S_BS_POS,
		S_BS_WR,
		S_POS_LAST,
		S_PR_WR,
		S_PR_RET,
		S_LF_POS,
		S_LF_SCROLL,
		S_LF_CLR
	} state_t;

	state_t state_q;
	state_t state_d;

	// A new byte is taken only between command runs
	assign char_stall = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					ctl.load_char = 1'b1;
					case (stat.kind)
						KIND_FF: begin
							ctl.col_op  = COL_ZERO;
							ctl.row_op  = ROW_ZERO;
							ctl.line_op = LINE_CLR;
							state_d     = S_FF_POS;
						end
						KIND_BS: begin
							// backspace at column zero does nothing
							if (!stat.col_zero) begin
								ctl.col_op = COL_DEC;
								state_d    = S_BS_POS;
							end
						end
						KIND_CR: begin
							ctl.col_op = COL_ZERO;
							state_d    = S_POS_LAST;
						end
						KIND_LF: state_d = S_LF_POS;
						default: state_d = S_PR_WR;
					endcase
				end
			end
			S_FF_POS: begin
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.cmd     = CMD_POSITION;
					ctl.col_sel = CSEL_CUR;
					ctl.row_sel = RSEL_CUR;
					state_d     = S_FF_CLR;
				end
			end
			S_FF_CLR: begin
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.cmd     = CMD_CLEAR;
					ctl.row_sel = RSEL_LINE;
					ctl.line_op = LINE_INC;
					if (stat.line_end) begin
						ctl.last = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_BS_POS: begin
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.cmd     = CMD_POSITION;
					ctl.col_sel = CSEL_CUR;
					ctl.row_sel = RSEL_CUR;
					state_d     = S_BS_WR;
				end
			end
			S_BS_WR: begin
				if (stat.out_free) begin
					ctl.emit      = 1'b1;
					ctl.cmd       = CMD_WRITE;
					ctl.glyph_sel = GSEL_SPACE;
					state_d       = S_POS_LAST;
				end
			end
			S_POS_LAST: begin
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.cmd     = CMD_POSITION;
					ctl.col_sel = CSEL_CUR;
					ctl.row_sel = RSEL_CUR;
					ctl.last    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_PR_WR: begin
				if (stat.out_free) begin
					ctl.emit      = 1'b1;
					ctl.cmd       = CMD_WRITE;
					ctl.glyph_sel = GSEL_CHAR;
					if (stat.col_end) begin
						state_d = S_PR_RET;
					end else begin
						ctl.col_op = COL_INC;
						ctl.last   = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			S_PR_RET: begin
				// wrap: carriage return, then line feed
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.cmd     = CMD_POSITION;
					ctl.col_sel = CSEL_ZERO;
					ctl.row_sel = RSEL_CUR;
					ctl.col_op  = COL_ZERO;
					state_d     = S_LF_POS;
				end
			end
			S_LF_POS: begin
				// row one past the bottom is shown before the scroll
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.cmd     = CMD_POSITION;
					ctl.col_sel = CSEL_CUR;
					ctl.row_sel = RSEL_NEXT;
					if (stat.row_bottom) begin
						state_d = S_LF_SCROLL;
					end else begin
						ctl.row_op = ROW_INC;
						ctl.last   = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			S_LF_SCROLL: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					ctl.cmd  = CMD_SCROLL;
					state_d  = S_LF_CLR;
				end
			end
			S_LF_CLR: begin
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.cmd     = CMD_CLEAR;
					ctl.row_sel = RSEL_CUR;
					state_d     = S_POS_LAST;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_console_cursor_control.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console cursor control for a 60 by 20 cell display. Each character
// byte taken on the char channel produces a run of display command words
// (set position, write character, clear line, scroll up) on the cmd channel,
// the final word of a run flagged by last; a backspace at column zero
// produces none. A run is one command word for most bytes, three for a
// backspace, four for a line feed that scrolls, 21 for a form feed and up
// to six for a character that wraps at the bottom row. The controller
// sequences one command word per cycle into the single output register
// while that register is free of a stalled word, and takes the next byte
// once a run is fully issued. Downstream stall holds a run until the
// output register is free.
module text_console_cursor_control import tccc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	output logic                   char_stall,
	input  wire logic [CHAR_W-1:0] char_code,
	output logic                   cmd_valid,
	input  wire logic              cmd_stall,
	output logic [1:0]             command,
	output logic [COL_W-1:0]       column,
	output logic [ROW_W-1:0]       row,
	output logic [CHAR_W-1:0]      glyph,
	output logic                   last
);

	tccc_ctl_t  ctl;
	tccc_stat_t stat;

	tccc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.stat       (stat),
		.ctl        (ctl)
	);

	tccc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.ctl       (ctl),
		.stat      (stat),
		.cmd_stall (cmd_stall),
		.cmd_valid (cmd_valid),
		.command   (command),
		.column    (column),
		.row       (row),
		.glyph     (glyph),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== rtl/tccc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_cursor_control_assert.svh"

module tccc_checker import tccc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_stall,
	input wire logic [1:0]        command,
	input wire logic [COL_W-1:0]  column,
	input wire logic [ROW_W-1:0]  row,
	input wire logic [CHAR_W-1:0] glyph,
	input wire logic              last
);

	logic is_write;
	logic is_scroll;
	logic is_pos;
	logic is_clear;

	// Offered word by command
	assign is_write  = cmd_valid && (command == CMD_WRITE);
	assign is_scroll = cmd_valid && (command == CMD_SCROLL);
	assign is_pos    = cmd_valid && (command == CMD_POSITION);
	assign is_clear  = cmd_valid && (command == CMD_CLEAR);

	// A stalled word stays offered
	`TCCC_ASSERT_NEXT(a_hold_valid, clk, arst_n, cmd_valid && cmd_stall, cmd_valid)

	// Write words carry no position
	`TCCC_ASSERT_IMPLY(a_write_nopos, clk, arst_n, is_write, (column == '0) && (row == '0))

	// A scroll never ends a run, as a clear always follows it, and carries no glyph
	`TCCC_ASSERT_IMPLY(a_scroll_not_last, clk, arst_n, is_scroll, !last && (glyph == '0))

	// Positions stay on the screen columns
	`TCCC_ASSERT_IMPLY(a_pos_column, clk, arst_n, is_pos, column < COL_W'(COLUMNS))

	// Cleared rows are real rows
	`TCCC_ASSERT_IMPLY(a_clear_row, clk, arst_n, is_clear, (row < ROW_W'(ROWS)) && (column == '0))

endmodule

bind text_console_cursor_control tccc_checker u_tccc_checker (.*);

`default_nettype wire
